// ===== rtl/core/cc20_pkg.sv =====
`default_nettype none
package cc20_pkg;

  typedef logic [31:0] word_t;

  // block input words, constants first
  typedef logic [15:0][31:0] block_t;

  // "expand 32-byte k" and "expand 16-byte k"
  localparam word_t SIGMA_LONG [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};
  localparam word_t SIGMA_SHORT[4] = '{32'h61707865, 32'h3120646e, 32'h79622d36, 32'h6b206574};

  // configuration register indexes
  localparam logic [2:0] REG_KEY01   = 3'd0;
  localparam logic [2:0] REG_KEY23   = 3'd1;
  localparam logic [2:0] REG_KEY45   = 3'd2;
  localparam logic [2:0] REG_KEY67   = 3'd3;
  localparam logic [2:0] REG_SHORT   = 3'd4;
  localparam logic [2:0] REG_COUNTER = 3'd5;
  localparam logic [2:0] REG_NONCE12 = 3'd6;
  localparam logic [2:0] REG_NONCE3  = 3'd7;

  // keystream memory write from the round engine
  typedef struct packed {
    logic       we;
    logic [3:0] addr;
    word_t      data;
  } ks_wr_t;

  // word addresses {a, b, c, d} of one quarter round
  function automatic logic [15:0] qr_index(input logic diag, input logic [1:0] q);
    logic [1:0] b, c, d;
    b = diag ? q + 2'd1 : q;
    c = diag ? q + 2'd2 : q;
    d = diag ? q + 2'd3 : q;
    return {2'b00, q, 2'b01, b, 2'b10, c, 2'b11, d};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cc20_in_if.sv =====
`default_nettype none
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cc20_out_if.sv =====
`default_nettype none
interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cc20_rounds.sv =====
`default_nettype none
module cc20_rounds #(
  parameter int ROUND_COUNT = 20
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire cc20_pkg::block_t init_words,
  output logic                 done,
  output cc20_pkg::ks_wr_t     ks_wr
);
  import cc20_pkg::*;

  localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  typedef enum logic [3:0] {
    C_IDLE, C_INIT, C_RAB, C_RCD, C_CAP, C_STEP,
    C_WA, C_WB, C_WC, C_WD, C_FRD, C_FWR
  } cstate_t;

  cstate_t     state_r;
  logic [3:0]  idx_r;
  logic [1:0]  q_r;
  logic [2:0]  step_r;
  logic [RW-1:0] rnd_r;
  word_t       va_r, vb_r, vc_r, vd_r;

  // working word memory, two read ports, one write port
  word_t       work_mem [16];
  word_t       rd0_r, rd1_r;
  logic [3:0]  ra0, ra1, wa;
  logic        we;
  word_t       wd;
  logic [15:0] qi;
  logic [3:0]  ia, ib, ic, id;

  assign qi = qr_index(rnd_r[0], q_r);
  assign ia = qi[15:12];
  assign ib = qi[11:8];
  assign ic = qi[7:4];
  assign id = qi[3:0];

  // memory address and write selection
  always_comb begin
    ra0 = idx_r;
    ra1 = ib;
    we  = 1'b0;
    wa  = idx_r;
    wd  = init_words[idx_r];
    unique case (state_r)
      C_INIT: we = 1'b1;
      C_RAB: begin
        ra0 = ia;
        ra1 = ib;
      end
      C_RCD: begin
        ra0 = ic;
        ra1 = id;
      end
      C_WA: begin
        we = 1'b1; wa = ia; wd = va_r;
      end
      C_WB: begin
        we = 1'b1; wa = ib; wd = vb_r;
      end
      C_WC: begin
        we = 1'b1; wa = ic; wd = vc_r;
      end
      C_WD: begin
        we = 1'b1; wa = id; wd = vd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      work_mem[wa] <= wd;
    end
    rd0_r <= work_mem[ra0];
    rd1_r <= work_mem[ra1];
  end

  // feed-forward write into the keystream memory
  always_comb begin
    ks_wr.we   = (state_r == C_FWR);
    ks_wr.addr = idx_r;
    ks_wr.data = rd0_r + init_words[idx_r];
  end
  assign done = (state_r == C_FWR) && (idx_r == 4'd15);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      idx_r   <= '0;
      q_r     <= '0;
      step_r  <= '0;
      rnd_r   <= '0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            state_r <= C_INIT;
            idx_r   <= '0;
          end
        end
        C_INIT: begin
          idx_r <= idx_r + 4'd1;
          if (idx_r == 4'd15) begin
            state_r <= C_RAB;
            q_r     <= '0;
            rnd_r   <= '0;
          end
        end
        C_RAB: state_r <= C_RCD;
        C_RCD: begin
          va_r    <= rd0_r;
          vb_r    <= rd1_r;
          state_r <= C_CAP;
        end
        C_CAP: begin
          vc_r    <= rd0_r;
          vd_r    <= rd1_r;
          step_r  <= '0;
          state_r <= C_STEP;
        end
        C_STEP: begin
          // one add or one xor-rotate per cycle
          unique case (step_r)
            3'd0, 3'd4: va_r <= va_r + vb_r;
            3'd1: vd_r <= {vd_r[15:0] ^ va_r[15:0], vd_r[31:16] ^ va_r[31:16]};
            3'd2, 3'd6: vc_r <= vc_r + vd_r;
            3'd3: vb_r <= {vb_r[19:0] ^ vc_r[19:0], vb_r[31:20] ^ vc_r[31:20]};
            3'd5: vd_r <= {vd_r[23:0] ^ va_r[23:0], vd_r[31:24] ^ va_r[31:24]};
            3'd7: vb_r <= {vb_r[24:0] ^ vc_r[24:0], vb_r[31:25] ^ vc_r[31:25]};
            default: ;
          endcase
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            state_r <= C_WA;
          end
        end
        C_WA: state_r <= C_WB;
        C_WB: state_r <= C_WC;
        C_WC: state_r <= C_WD;
        C_WD: begin
          q_r <= q_r + 2'd1;
          if (q_r == 2'd3) begin
            if (rnd_r == RW'(ROUND_COUNT - 1)) begin
              state_r <= C_FRD;
              idx_r   <= '0;
            end else begin
              rnd_r   <= rnd_r + RW'(1);
              state_r <= C_RAB;
            end
          end else begin
            state_r <= C_RAB;
          end
        end
        C_FRD: state_r <= C_FWR;
        C_FWR: begin
          idx_r <= idx_r + 4'd1;
          state_r <= (idx_r == 4'd15) ? C_IDLE : C_FRD;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/chacha20_keystream_cipher.sv =====
`default_nettype none
// channel   dir  request fields           handshake
// in_ch     in   data_byte[8], restart[1]  valid/ready
// out_ch    out  out_byte[8]               valid/ready
// cfg_*     in   cfg_idx[3], cfg_wdata[64] cfg_we, no wait
//
// a byte passes T_IDLE, T_READ and T_OUT when the block is at hand; one byte
// is in flight at a time. every 64th byte or restart adds a block build: start
// handoff, 16 loads, per quarter round on the shared word memory paired reads,
// eight add or xor-rotate steps and four writes, then feed-forward of each word.
// synchronous active-low reset clears control, counter and position.
// a stalled result holds the next byte in T_OUT; input waits until it drains.
module chacha20_keystream_cipher #(
  parameter int ROUND_COUNT = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cc20_in_if.sink          in_ch,
  cc20_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [63:0] cfg_wdata
);
  import cc20_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_BUILD, T_READ, T_OUT} tstate_t;

  logic [63:0] key01_r, key23_r, key45_r, key67_r, nonce12_r;
  logic        short_r;
  word_t       ctr_init_r, nonce3_r;

  tstate_t     state_r;
  word_t       ctr_r;
  logic [5:0]  pos_r;
  logic [7:0]  data_r;
  logic        start_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;

  block_t      init_words;
  logic        done;
  ks_wr_t      ks_wr;
  word_t       ks_mem [16];
  word_t       ks_rd_r;
  logic [5:0]  pos_nxt;
  word_t       ctr_nxt;
  word_t       ks_shift;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r <= '0; key23_r <= '0; key45_r <= '0; key67_r <= '0;
      short_r <= 1'b0; ctr_init_r <= '0; nonce12_r <= '0; nonce3_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KEY01:   key01_r    <= cfg_wdata;
        REG_KEY23:   key23_r    <= cfg_wdata;
        REG_KEY45:   key45_r    <= cfg_wdata;
        REG_KEY67:   key67_r    <= cfg_wdata;
        REG_SHORT:   short_r    <= cfg_wdata[0];
        REG_COUNTER: ctr_init_r <= cfg_wdata[31:0];
        REG_NONCE12: nonce12_r  <= cfg_wdata;
        REG_NONCE3:  nonce3_r   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // block input words
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_words[i] = short_r ? SIGMA_SHORT[i] : SIGMA_LONG[i];
    end
    init_words[4]  = key01_r[31:0];
    init_words[5]  = key01_r[63:32];
    init_words[6]  = key23_r[31:0];
    init_words[7]  = key23_r[63:32];
    init_words[8]  = short_r ? key01_r[31:0]  : key45_r[31:0];
    init_words[9]  = short_r ? key01_r[63:32] : key45_r[63:32];
    init_words[10] = short_r ? key23_r[31:0]  : key67_r[31:0];
    init_words[11] = short_r ? key23_r[63:32] : key67_r[63:32];
    init_words[12] = ctr_r;
    init_words[13] = nonce12_r[31:0];
    init_words[14] = nonce12_r[63:32];
    init_words[15] = nonce3_r;
  end

  cc20_rounds #(.ROUND_COUNT(ROUND_COUNT)) u_rounds (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start_r),
    .init_words (init_words),
    .done       (done),
    .ks_wr      (ks_wr)
  );

  // keystream block memory
  always_ff @(posedge clk) begin
    if (ks_wr.we) begin
      ks_mem[ks_wr.addr] <= ks_wr.data;
    end
    ks_rd_r <= ks_mem[pos_r[5:2]];
  end

  assign in_ch.ready     = (state_r == T_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

  assign pos_nxt  = in_ch.restart ? 6'd0 : pos_r;
  assign ctr_nxt  = in_ch.restart ? ctr_init_r : ctr_r;
  assign ks_shift = ks_rd_r >> {pos_r[1:0], 3'b000};

  // byte sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      ctr_r       <= '0;
      pos_r       <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      // result taken while no new one is being loaded
      if (out_valid_r && out_ch.ready && state_r != T_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (in_ch.valid) begin
            data_r <= in_ch.data_byte;
            pos_r  <= pos_nxt;
            ctr_r  <= ctr_nxt;
            if (pos_nxt == 6'd0) begin
              start_r <= 1'b1;
              state_r <= T_BUILD;
            end else begin
              state_r <= T_READ;
            end
          end
        end
        T_BUILD: begin
          if (done) begin
            ctr_r   <= ctr_r + 32'd1;
            state_r <= T_READ;
          end
        end
        T_READ: state_r <= T_OUT;
        T_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_byte_r  <= data_r ^ ks_shift[7:0];
            out_valid_r <= 1'b1;
            pos_r       <= pos_r + 6'd1;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
